/* hdl/tcf_pkg.sv */
// ----------------------------------------------------------------------------
// tcf_pkg: shared types and constants of the tilt filter
// Register indexes, fixed-point limits and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tcf_pkg;

  localparam int ATAN_ENTRIES = 24;

  localparam logic [2:0] REG_ACCEL_OFFSET_X = 3'd0;
  localparam logic [2:0] REG_ACCEL_OFFSET_Z = 3'd1;
  localparam logic [2:0] REG_GYRO_OFFSET_X  = 3'd2;
  localparam logic [2:0] REG_GAIN_P         = 3'd3;
  localparam logic [2:0] REG_GAIN_I         = 3'd4;
  localparam logic [2:0] REG_GAIN_D         = 3'd5;
  localparam logic [2:0] REG_TARGET_ANGLE   = 3'd6;
  localparam logic [2:0] REG_SAMPLE_PERIOD  = 3'd7;

  localparam logic signed [25:0] ANG_180 = 26'sd11796480;
  localparam logic signed [25:0] ANG_90  = 26'sd5898240;

  // atan(2^-i) in degrees, Q16.
  function automatic logic [21:0] atan_deg(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234378;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/tilt_complementary_filter_pid.sv */
// ----------------------------------------------------------------------------
// tilt_complementary_filter_pid: tilt estimator with PID drive
// Accelerometer angle by CORDIC, complementary blend with the gyro rate,
// and a PID step with saturating integral and drive.
//
//   channel  dir  beat content
//   s_axis   in   tdata {gyro_x_raw, accel_z_raw, accel_x_raw}
//   m_axis   out  tdata {drive_value, accel_angle, tilt_estimate}, tuser strobe
//   cfg      in   index, data
//
// One tick at a time; the CORDIC is skipped when the corrected X is zero. The
// CORDIC runs one iteration a cycle, each of the three divisions runs at one
// quotient bit a cycle, and products share one 33x33 multiplier.
// Reset clears state and loads register defaults. A waiting result blocks the
// input until it is accepted.
// ----------------------------------------------------------------------------
module tilt_complementary_filter_pid
  import tcf_pkg::*;
#(
  parameter int REPORT_DIVIDE = 20,
  parameter int CORDIC_STEPS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // accel_x_raw, accel_z_raw, gyro_x_raw
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // tilt_estimate, accel_angle, drive_value
  output logic        m_axis_tuser,   // report_strobe
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [25:0] cfg_data
);

  localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);
  localparam logic [4:0] DIV_LIMIT = 5'(REPORT_DIVIDE);

  typedef enum logic [4:0] {
    S_IDLE, S_PRE, S_CORDIC, S_DLT_M, S_DLT_DIV, S_BLEND, S_BLEND_DIV, S_ERR,
    S_P, S_INT_M, S_INT_ADD, S_I, S_DER_DIV, S_D, S_D2, S_SUM, S_OUT
  } state_t;

  state_t state;

  logic signed [16:0] ofs_ax, ofs_az;
  logic signed [15:0] ofs_gx;
  logic signed [24:0] kp, ki, kd;
  logic signed [25:0] target;
  logic [19:0] period;

  logic signed [25:0] tilt_reg;
  logic signed [31:0] integ;
  logic signed [26:0] last_err;
  logic [4:0] tick;

  logic signed [17:0] ax, az, gx;
  logic signed [31:0] cx, cy;
  logic signed [25:0] cz;
  logic [4:0] step;
  logic signed [24:0] acc;
  logic signed [26:0] err;
  logic signed [63:0] p_term, i_term, drive_acc;
  logic signed [63:0] prod_hold;
  logic [19:0] dt;

  // Shared restoring divider: magnitude of num over den, one bit a cycle.
  logic [63:0] dnum;
  logic [63:0] dquo;
  logic [64:0] drem;
  logic [42:0] dden;
  logic [6:0]  dcnt;
  logic        dneg;

  // Shared multiplier.
  logic signed [32:0] ma, mb;
  logic signed [65:0] mprod;
  assign mprod = ma * mb;

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign cfg_ready = 1'b1;

  logic [64:0] drem_sh;
  logic [64:0] dden_x;
  assign drem_sh = {drem[63:0], dnum[63]};
  assign dden_x  = 65'(dden);

  // floor result of signed division with rounding handled by caller:
  // q = floor(n/d) for sign-magnitude form.
  logic signed [64:0] dfloor;
  always_comb begin
    if (!dneg) dfloor = $signed({1'b0, dquo});
    else if (drem != 65'd0) dfloor = -$signed({1'b0, dquo}) - 65'sd1;
    else dfloor = -$signed({1'b0, dquo});
  end

  logic signed [31:0] xs, ys;
  assign xs = cx >>> step;
  assign ys = cy >>> step;

  logic signed [63:0] rnd16;
  assign rnd16 = 64'(mprod + 66'sd32768) >>> 16;

  // The derivative is too wide for one product, so the D term is formed from
  // its upper part in S_D and its low 16 bits in S_D2.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_DLT_M:  begin ma = 33'(gx);  mb = $signed({13'd0, dt}); end
      S_P:      begin ma = 33'(kp);  mb = 33'(err); end
      S_INT_M:  begin ma = 33'(err); mb = $signed({13'd0, dt}); end
      S_I:      begin ma = 33'(ki);  mb = 33'(integ); end
      S_D:      begin ma = 33'(kd);  mb = prod_hold[48:16]; end
      S_D2:     begin ma = 33'(kd);  mb = $signed({17'd0, prod_hold[15:0]}); end
      default:  begin ma = '0; mb = '0; end
    endcase
  end

  // Starts a division of 2n+d by 2d in sign-magnitude form.
  task automatic start_div(input logic signed [63:0] n2d, input logic [42:0] d2);
    dneg <= n2d[63];
    dnum <= n2d[63] ? 64'(-n2d) : n2d;
    dden <= d2;
    drem <= '0;
    dquo <= '0;
    dcnt <= 7'd64;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      ofs_ax <= '0; ofs_az <= '0; ofs_gx <= '0;
      kp <= 25'sd65536; ki <= '0; kd <= '0; target <= '0;
      period <= 20'd5243;
      tilt_reg <= '0; integ <= '0; last_err <= '0; tick <= '0;
      dcnt <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ACCEL_OFFSET_X: ofs_ax <= cfg_data[16:0];
          REG_ACCEL_OFFSET_Z: ofs_az <= cfg_data[16:0];
          REG_GYRO_OFFSET_X:  ofs_gx <= cfg_data[15:0];
          REG_GAIN_P:         kp <= cfg_data[24:0];
          REG_GAIN_I:         ki <= cfg_data[24:0];
          REG_GAIN_D:         kd <= cfg_data[24:0];
          REG_TARGET_ANGLE:   target <= cfg_data;
          REG_SAMPLE_PERIOD:  period <= cfg_data[19:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (dcnt != 7'd0) begin
        if (drem_sh >= dden_x) begin
          drem <= drem_sh - dden_x;
          dquo <= {dquo[62:0], 1'b1};
        end else begin
          drem <= drem_sh;
          dquo <= {dquo[62:0], 1'b0};
        end
        dnum <= {dnum[62:0], 1'b0};
        dcnt <= dcnt - 7'd1;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            ax <= 18'(signed'(s_axis_tdata[15:0])) - 18'(ofs_ax);
            az <= 18'(signed'(s_axis_tdata[31:16])) - 18'(ofs_az);
            gx <= 18'(signed'(s_axis_tdata[47:32])) - 18'(ofs_gx);
            dt <= (period == 20'd0) ? 20'd1 : period;
            state <= S_PRE;
          end
        end
        S_PRE: begin
          step <= '0;
          if (ax == 18'sd0) begin
            acc <= (az < 0) ? 25'(ANG_180) : '0;
            state <= S_DLT_M;
          end else if (az < 0) begin
            cx <= ax >= 0 ? 32'(ax) <<< 12 : 32'(-ax) <<< 12;
            cy <= ax >= 0 ? -(32'(az) <<< 12) : 32'(az) <<< 12;
            cz <= ax >= 0 ? ANG_90 : -ANG_90;
            state <= S_CORDIC;
          end else begin
            cx <= 32'(az) <<< 12;
            cy <= 32'(ax) <<< 12;
            cz <= '0;
            state <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (cy >= 0) begin
            cx <= cx + ys; cy <= cy - xs; cz <= cz + 26'(atan_deg(step));
          end else begin
            cx <= cx - ys; cy <= cy + xs; cz <= cz - 26'(atan_deg(step));
          end
          step <= step + 5'd1;
          if (step == LAST_STEP) state <= S_BLEND;
        end
        S_BLEND: begin
          // Clamp the CORDIC angle, then form the gyro product.
          if (cz > ANG_180) acc <= 25'(ANG_180);
          else if (cz < -ANG_180) acc <= 25'(-ANG_180);
          else acc <= 25'(cz);
          state <= S_DLT_M;
        end
        S_DLT_M: begin
          start_div(2 * 64'(mprod) * 7 + 64'sd12800, 43'd25600);
          state <= S_DLT_DIV;
        end
        S_DLT_DIV: begin
          if (dcnt == 7'd0) begin
            start_div(2 * (49 * (64'(tilt_reg) + 64'(dfloor)) + 64'(acc)) + 64'sd50,
                      43'd100);
            state <= S_BLEND_DIV;
          end
        end
        S_BLEND_DIV: begin
          if (dcnt == 7'd0) state <= S_ERR;
        end
        S_ERR: begin
          logic signed [25:0] t;
          if (dfloor > 65'sd33554431) t = 26'sd33554431;
          else if (dfloor < -65'sd33554432) t = -26'sd33554432;
          else t = 26'(dfloor);
          tilt_reg <= t;
          err <= 27'(target) - 27'(t);
          state <= S_P;
        end
        S_P: begin
          p_term <= rnd16;
          state <= S_INT_M;
        end
        S_INT_M: begin
          prod_hold <= 64'(mprod + 66'sd524288) >>> 20;
          state <= S_INT_ADD;
        end
        S_INT_ADD: begin
          logic signed [64:0] s;
          s = 65'(integ) + 65'(prod_hold);
          if (s > 65'sd2147483647) integ <= 32'sh7fffffff;
          else if (s < -65'sd2147483648) integ <= 32'sh80000000;
          else integ <= 32'(s);
          state <= S_I;
        end
        S_I: begin
          i_term <= rnd16;
          start_div(2 * ((64'(err) - 64'(last_err)) <<< 20) + 64'(dt),
                    43'({dt, 1'b0}));
          state <= S_DER_DIV;
        end
        S_DER_DIV: begin
          if (dcnt == 7'd0) begin
            prod_hold <= 64'(dfloor);
            state <= S_D;
          end
        end
        S_D: begin
          drive_acc <= p_term + i_term + 64'(mprod);
          last_err <= err;
          state <= S_D2;
        end
        S_D2: begin
          drive_acc <= drive_acc + rnd16;
          state <= S_SUM;
        end
        S_SUM: begin
          logic [4:0] tn;
          tn = tick + 5'd1;
          if (tn >= DIV_LIMIT) begin
            tick <= '0; m_axis_tuser <= 1'b1;
          end else begin
            tick <= tn; m_axis_tuser <= 1'b0;
          end
          m_axis_tdata[25:0] <= tilt_reg;
          m_axis_tdata[50:26] <= acc;
          if (drive_acc > 64'sd2147483647) m_axis_tdata[82:51] <= 32'h7fffffff;
          else if (drive_acc < -64'sd2147483648) m_axis_tdata[82:51] <= 32'h80000000;
          else m_axis_tdata[82:51] <= drive_acc[31:0];
          m_axis_tdata[87:83] <= '0;
          state <= S_OUT;
        end
        S_OUT: begin
          m_axis_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/tcf_checker.sv */
// ----------------------------------------------------------------------------
// tcf_checker: result predictor and scoreboard for the tilt filter
// Watches the configuration, input and result channels. It keeps its own copy
// of the registers and filter state, predicts one result beat per input beat
// and compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tcf_checker
  import tcf_pkg::*;
#(
  parameter int REPORT_DIVIDE = 20,
  parameter int CORDIC_STEPS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [87:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [25:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic signed [25:0] tilt;
    logic signed [24:0] accel_angle;
    logic signed [31:0] drive;
    logic               strobe;
  } tick_result_t;

  localparam longint TILT_MIN  = -33554432;
  localparam longint TILT_MAX  = 33554431;
  localparam longint DRIVE_MIN = -64'sd2147483648;
  localparam longint DRIVE_MAX = 2147483647;

  // atan(2^-i) in degrees, Q16.
  localparam longint ATAN_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234378, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  tick_result_t expected_q[$];

  // Register copies.
  longint off_ax, off_az, off_gx, kp, ki, kd, setpoint, period;
  // Filter state.
  longint tilt_q16, integral, prev_err;
  int     ticks;

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint round_quot(longint n, longint d);
    return floor_quot(2 * n + d, 2 * d);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint gain_product(longint g, longint v);
    longint hi, lo;
    hi = floor_quot(v, 65536);
    lo = v - hi * 65536;
    return g * hi + floor_quot(g * lo + 32768, 65536);
  endfunction

  function automatic longint accel_degrees(longint y, longint x);
    longint ang, t, xs, ys;
    int     steps;
    ang = 0;
    if (y == 0) return x < 0 ? longint'(ANG_180) : 0;
    x = x * 4096;
    y = y * 4096;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; ang = ANG_90;
      end else begin
        t = x; x = -y; y = t; ang = -longint'(ANG_90);
      end
    end
    steps = CORDIC_STEPS > 24 ? 24 : CORDIC_STEPS;
    for (int i = 0; i < steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; ang += ATAN_Q16[i];
      end else begin
        x -= ys; y += xs; ang -= ATAN_Q16[i];
      end
    end
    return clamp(ang, -longint'(ANG_180), longint'(ANG_180));
  endfunction

  function automatic tick_result_t next_tick(logic [47:0] beat);
    tick_result_t r;
    longint ax, az, gx, dt, acc, delta, tilt, err, p, i, d;
    ax = longint'($signed(beat[15:0])) - off_ax;
    az = longint'($signed(beat[31:16])) - off_az;
    gx = longint'($signed(beat[47:32])) - off_gx;
    dt = period != 0 ? period : 1;
    acc = accel_degrees(ax, az);
    delta = round_quot(gx * dt * 7, 12800);
    tilt = clamp(round_quot(49 * (tilt_q16 + delta) + acc, 50), TILT_MIN, TILT_MAX);
    tilt_q16 = tilt;
    err = setpoint - tilt;
    p = gain_product(kp, err);
    integral = clamp(integral + round_quot(err * dt, 1048576), DRIVE_MIN, DRIVE_MAX);
    i = gain_product(ki, integral);
    d = gain_product(kd, round_quot((err - prev_err) * 1048576, dt));
    prev_err = err;
    ticks = (ticks + 1) & 31;
    r.strobe = 1'b0;
    if (ticks >= REPORT_DIVIDE) begin
      r.strobe = 1'b1;
      ticks = 0;
    end
    r.tilt = tilt[25:0];
    r.accel_angle = acc[24:0];
    r.drive = 32'(clamp(p + i + d, DRIVE_MIN, DRIVE_MAX));
    return r;
  endfunction

  always @(posedge clk) begin
    tick_result_t want, got;
    if (rst) begin
      off_ax = 0; off_az = 0; off_gx = 0;
      kp = 65536; ki = 0; kd = 0; setpoint = 0; period = 5243;
      tilt_q16 = 0; integral = 0; prev_err = 0; ticks = 0;
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACCEL_OFFSET_X: off_ax = longint'($signed(cfg_data[16:0]));
          REG_ACCEL_OFFSET_Z: off_az = longint'($signed(cfg_data[16:0]));
          REG_GYRO_OFFSET_X:  off_gx = longint'($signed(cfg_data[15:0]));
          REG_GAIN_P:         kp = longint'($signed(cfg_data[24:0]));
          REG_GAIN_I:         ki = longint'($signed(cfg_data[24:0]));
          REG_GAIN_D:         kd = longint'($signed(cfg_data[24:0]));
          REG_TARGET_ANGLE:   setpoint = longint'($signed(cfg_data[25:0]));
          REG_SAMPLE_PERIOD:  period = longint'(cfg_data[19:0]);
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(next_tick(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.tilt = m_axis_tdata[25:0];
        got.accel_angle = m_axis_tdata[50:26];
        got.drive = m_axis_tdata[82:51];
        got.strobe = m_axis_tuser;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result beat with nothing expected: %h", m_axis_tdata);
        end else begin
          want = expected_q.pop_front();
          if (got !== want || m_axis_tdata[87:83] !== 5'd0) begin
            errors++;
            if (errors <= 10)
              $display("mismatch tilt %0d/%0d angle %0d/%0d drive %0d/%0d strobe %0b/%0b pad %h",
                       want.tilt, got.tilt, want.accel_angle, got.accel_angle,
                       want.drive, got.drive, want.strobe, got.strobe,
                       m_axis_tdata[87:83]);
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

/* tb/tilt_complementary_filter_pid_tb.sv */
// ----------------------------------------------------------------------------
// tilt_complementary_filter_pid_tb: stimulus and verdict for the tilt filter
// Directed ticks cover sensor extremes, the zero-X angle cases and saturation;
// then random phases rewrite every register while idle and stream random ticks.
// Some phases add random gaps and output stalls. A checker predicts each result.
// ----------------------------------------------------------------------------
module tilt_complementary_filter_pid_tb;
  import tcf_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // accel_x_raw, accel_z_raw, gyro_x_raw
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;        // tilt_estimate, accel_angle, drive_value
  logic        m_axis_tuser;        // report_strobe
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [25:0] cfg_data = '0;
  int          errors, pending;
  bit          rx_busy_mode = 1'b0;
  bit          tx_gaps = 1'b0;
  int          stall_left = 0;

  always #5 clk = ~clk;

  tilt_complementary_filter_pid dut (.*);
  tcf_checker chk (.*);

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_busy_mode && $urandom_range(0, 3) == 0) begin
      stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 200)
                                                 : $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic write_reg(logic [2:0] idx, logic [25:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_tick(logic [15:0] ax, logic [15:0] az, logic [15:0] gx);
    int gap;
    s_axis_tdata <= {gx, az, ax};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    gap = 0;
    if (tx_gaps && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [25:0] pick(int lo, int hi, int typ);
    case ($urandom_range(0, 5))
      0: return 26'(lo);
      1: return 26'(hi);
      2: return 26'($urandom_range(0, 2 * typ) - typ);
      default: return 26'($urandom_range(0, hi - lo) + lo);
    endcase
  endfunction

  task automatic random_config();
    write_reg(REG_ACCEL_OFFSET_X, pick(-65536, 65535, 800));
    write_reg(REG_ACCEL_OFFSET_Z, 26'(pick(-65536, 65535, 800) - 16000));
    write_reg(REG_GYRO_OFFSET_X, pick(-32768, 32767, 300));
    write_reg(REG_GAIN_P, pick(-16777216, 16777215, 300000));
    write_reg(REG_GAIN_I, pick(-16777216, 16777215, 100000));
    write_reg(REG_GAIN_D, pick(-16777216, 16777215, 2000));
    write_reg(REG_TARGET_ANGLE, pick(-33554432, 33554431, 3000000));
    case ($urandom_range(0, 4))
      0: write_reg(REG_SAMPLE_PERIOD, 26'(1048575));
      1: write_reg(REG_SAMPLE_PERIOD, 26'($urandom_range(0, 1)));
      2: write_reg(REG_SAMPLE_PERIOD, 26'($urandom_range(0, 1048575)));
      default: write_reg(REG_SAMPLE_PERIOD, 26'($urandom_range(1000, 20000)));
    endcase
  endtask

  initial begin
    int ang_scale, ax, az;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sensor extremes and the zero-X angle cases under default registers.
    send_tick(16'h0000, 16'h0000, 16'h0000);
    send_tick(16'h0000, 16'd16000, 16'h0000);
    send_tick(16'h0000, 16'h8000, 16'h0000);
    send_tick(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_tick(16'h8000, 16'h8000, 16'h8000);
    send_tick(16'h7FFF, 16'h8000, 16'h0001);
    send_tick(16'h8000, 16'h7FFF, 16'hFFFF);
    send_tick(16'h0001, 16'h8000, 16'h0000);
    send_tick(16'hFFFF, 16'h8000, 16'h0000);
    send_tick(16'h7FFF, 16'h0000, 16'h0000);
    send_tick(16'h8000, 16'h0000, 16'h0000);
    drain();

    // Tilt, integral and drive saturation: huge rate, longest period, big gains.
    write_reg(REG_GYRO_OFFSET_X, 26'(-32768));
    write_reg(REG_ACCEL_OFFSET_X, 26'(65535));
    write_reg(REG_ACCEL_OFFSET_Z, 26'(-65536));
    write_reg(REG_SAMPLE_PERIOD, 26'(1048575));
    write_reg(REG_GAIN_P, 26'(16777215));
    write_reg(REG_GAIN_I, 26'(-16777216));
    write_reg(REG_GAIN_D, 26'(16777215));
    write_reg(REG_TARGET_ANGLE, 26'(-33554432));
    repeat (6) send_tick(16'h8000, 16'h7FFF, 16'h7FFF);
    drain();
    write_reg(REG_SAMPLE_PERIOD, 26'd0);
    repeat (6) send_tick(16'h7FFF, 16'h8000, 16'h8000);
    drain();

    // Random phases, each with a fresh register set.
    for (int ph = 0; ph < 12; ph++) begin
      random_config();
      tx_gaps = (ph % 3) != 0;
      rx_busy_mode = (ph % 4) != 1;
      for (int n = 0; n < 136; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_tick(16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
          // Plausible gravity vector at a random angle, plus sensor noise.
          ang_scale = $urandom_range(0, 32000) - 16000;
          ax = ang_scale + $urandom_range(0, 400) - 200;
          az = (ang_scale < 0 ? -ang_scale : ang_scale) - 16000 * ($urandom_range(0, 1) ? 1 : -1)
               + $urandom_range(0, 400) - 200;
          send_tick(16'(ax), 16'(az), 16'($urandom_range(0, 4000) - 2000));
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
